// ----- hdl/wheel_angle_velocity_estimator_assert.svh -----
// Assertion macros shared by the estimator's RTL files.
// IMP checks a same-cycle implication and NXT a next-cycle one.
`ifndef WHEEL_ANGLE_VELOCITY_ESTIMATOR_ASSERT_SVH
`define WHEEL_ANGLE_VELOCITY_ESTIMATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define WAVE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define WAVE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define WAVE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define WAVE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- hdl/wave_pkg.sv -----
package wave_pkg;

	// field widths
	localparam int RAW_W      = 17;
	localparam int TS_W       = 32;
	localparam int ANGLE_W    = 20;
	localparam int VEL_W      = 32;
	localparam int RANGE_W    = 12;
	localparam int TAU_W      = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	// default fixed-point formats
	localparam int ANGLE_FRAC_BITS_DEF    = 8;
	localparam int VELOCITY_FRAC_BITS_DEF = 4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_MIN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_MAX  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_DEG = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TAU_US    = 2'd3;

	// register reset values
	localparam logic signed [RAW_W-1:0] AXIS_MIN_RST  = 17'sd0;
	localparam logic signed [RAW_W-1:0] AXIS_MAX_RST  = 17'sd65535;
	localparam logic [RANGE_W-1:0]      RANGE_DEF     = 12'd1080;
	localparam logic [TAU_W-1:0]        TAU_RST       = 20'd20000;

	// arithmetic constants
	localparam int                      MUL_A_W  = 33;
	localparam int                      MUL_B_W  = 21;
	localparam int                      PROD_W   = MUL_A_W + MUL_B_W;
	localparam logic signed [MUL_B_W-1:0] US_PER_S = 21'sd1000000;
	localparam int                      A_FRAC   = 16;
	localparam logic signed [VEL_W-1:0] VEL_MAX  = 32'sh7FFF_FFFF;
	localparam logic signed [VEL_W-1:0] VEL_MIN  = 32'sh8000_0000;
	localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 20'sh7FFFF;
	localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = 20'sh80000;

	// shared divider: quotient bits per division
	localparam int QUOT_W = 32;
	localparam int CNT_W  = 6;
	localparam int QA_W   = 20;
	localparam int QV_W   = 32;
	localparam int QK_W   = 17;

	typedef struct packed {
		logic signed [RAW_W-1:0] axis_min;
		logic signed [RAW_W-1:0] axis_max;
		logic [RANGE_W-1:0]      range_eff;
		logic [TAU_W-1:0]        tau_us;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] count;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} div_sts_t;

endpackage

// ----- hdl/wave_cfg.sv -----
module wave_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [wave_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wave_pkg::CFG_DATA_W-1:0] cfg_data,
	output wave_pkg::cfg_t                  cfg
);
	import wave_pkg::*;

	logic signed [RAW_W-1:0] axis_min_q;
	logic signed [RAW_W-1:0] axis_max_q;
	logic [RANGE_W-1:0]      range_q;
	logic [TAU_W-1:0]        tau_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_min_q <= AXIS_MIN_RST;
			axis_max_q <= AXIS_MAX_RST;
			range_q    <= RANGE_DEF;
			tau_q      <= TAU_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_AXIS_MIN:  axis_min_q <= cfg_data[RAW_W-1:0];
				REG_AXIS_MAX:  axis_max_q <= cfg_data[RAW_W-1:0];
				REG_RANGE_DEG: range_q    <= cfg_data[RANGE_W-1:0];
				REG_TAU_US:    tau_q      <= cfg_data[TAU_W-1:0];
				default: ;
			endcase
		end
	end

	// zero range falls back to the default
	assign cfg.axis_min  = axis_min_q;
	assign cfg.axis_max  = axis_max_q;
	assign cfg.range_eff = (range_q == '0) ? RANGE_DEF : range_q;
	assign cfg.tau_us    = tau_q;

endmodule

// ----- hdl/wave_div.sv -----
`include "wheel_angle_velocity_estimator_assert.svh"
module wave_div #(
	parameter int DVD_W = 61,
	parameter int DVS_W = 41
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  wave_pkg::div_req_t           req,
	input  logic [DVD_W-1:0]             hi,
	input  logic [wave_pkg::QUOT_W-1:0]  lo,
	input  logic [DVS_W-1:0]             den,
	output wave_pkg::div_sts_t           sts,
	output logic [wave_pkg::QUOT_W-1:0]  quot
);
	import wave_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic             ovf_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] den_q;
	logic [QUOT_W-1:0] lo_q;
	logic [QUOT_W-1:0] quot_q;

	logic [DVS_W:0] trial;
	logic           fits;
	logic [DVS_W:0] diff;

	// one restoring step: bring down the next dividend bit, subtract if it fits
	assign trial = {rem_q, lo_q[QUOT_W-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				den_q  <= den;
				quot_q <= '0;
				lo_q   <= lo;
				cnt_q  <= req.count;
				if (hi >= DVD_W'(den)) begin
					ovf_q  <= 1'b1;
					done_q <= 1'b1;
				end else begin
					ovf_q  <= 1'b0;
					busy_q <= 1'b1;
					rem_q  <= hi[DVS_W-1:0];
				end
			end else if (busy_q) begin
				rem_q  <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
				quot_q <= {quot_q[QUOT_W-2:0], fits};
				lo_q   <= lo_q << 1;
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign sts.done = done_q;
	assign sts.ovf  = ovf_q;
	assign quot     = quot_q;

	`WAVE_ASSERT_IMP(a_no_restart, clk, arst_n, req.start, !busy_q, "divider restarted while busy")
	`WAVE_ASSERT_IMP(a_rem_below_den, clk, arst_n, busy_q, rem_q < den_q, "remainder reached divisor")
	`WAVE_ASSERT_NXT(a_done_pulse, clk, arst_n, done_q, !done_q, "done held for two cycles")

endmodule

// ----- hdl/wheel_angle_velocity_estimator.sv -----
// Channel   Handshake                 Payload
// cfg       cfg_we                    cfg_index, cfg_data
// in        in_valid / in_ready       raw_position, timestamp_us
// out       out_valid / out_ready     angle_q8, velocity_q4, velocity_valid
//
// One item at a time; in_ready is high only in idle. Each item runs divisions of 20, 32 and
// 17 steps on the shared restoring divider. The first sample or a repeated timestamp skips
// the last two divisions; an empty or inverted span skips the angle division. A stalled
// result holds the next item in its last state.
// Reset clears the state and restores register defaults.
`include "wheel_angle_velocity_estimator_assert.svh"
module wheel_angle_velocity_estimator #(
	parameter int ANGLE_FRAC_BITS    = wave_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int VELOCITY_FRAC_BITS = wave_pkg::VELOCITY_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [wave_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wave_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [wave_pkg::RAW_W-1:0]   raw_position,
	input  logic [wave_pkg::TS_W-1:0]           timestamp_us,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [wave_pkg::ANGLE_W-1:0] angle_q8,
	output logic signed [wave_pkg::VEL_W-1:0]   velocity_q4,
	output logic                                velocity_valid
);
	import wave_pkg::*;

	// divider widths cover the largest angle, velocity and smoothing operands
	localparam int DVD_W = 49 + ANGLE_FRAC_BITS + VELOCITY_FRAC_BITS;
	localparam int DVS_W = 33 + ANGLE_FRAC_BITS;
	localparam int SPAN_W = RAW_W + 1;
	localparam int DIFF_W = ANGLE_W + 1;
	localparam int NV_W   = VEL_W + 4;

	typedef enum logic [4:0] {
		S_IDLE, S_PREP, S_AMUL, S_APREP, S_ADIV, S_AWAIT,
		S_VSTART, S_VMUL, S_VPREP, S_VDIV, S_VWAIT,
		S_KPREP, S_KDIV, S_KWAIT, S_SMUL, S_SUPD, S_OUT
	} state_t;

	state_t state_q;

	cfg_t     cfg;
	div_req_t div_req;
	div_sts_t div_sts;
	logic [QUOT_W-1:0] div_quot;

	// item and working registers
	logic signed [RAW_W-1:0]   raw_q;
	logic [TS_W-1:0]           ts_q;
	logic [TS_W-1:0]           dt_q;
	logic [SPAN_W-1:0]         span_q;
	logic                      sign_q;
	logic signed [ANGLE_W-1:0] angle_q;
	logic signed [VEL_W-1:0]   dv_q;
	logic signed [MUL_A_W-1:0] mul_a_q;
	logic signed [MUL_B_W-1:0] mul_b_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic [DVD_W-1:0]          div_hi_q;
	logic [QUOT_W-1:0]         div_lo_q;
	logic [DVS_W-1:0]          div_den_q;
	logic [CNT_W-1:0]          div_cnt_q;

	// carried state
	logic signed [ANGLE_W-1:0] prev_angle_q;
	logic signed [VEL_W-1:0]   vel_q;
	logic [TS_W-1:0]           last_ts_q;
	logic                      have_prev_q;

	// result register
	logic                      out_valid_q;
	logic signed [ANGLE_W-1:0] out_angle_q;
	logic signed [VEL_W-1:0]   out_vel_q;
	logic                      out_vvalid_q;

	// combinational helpers
	logic signed [SPAN_W-1:0]  span_c;
	logic signed [SPAN_W-1:0]  rel_c;
	logic signed [ANGLE_W-1:0] twice_c;
	logic signed [PROD_W-1:0]  prod_c;
	logic [PROD_W-1:0]         prod_mag_c;
	logic [DVD_W-1:0]          amag_c;
	logic [DVD_W-1:0]          vmag_c;
	logic [TS_W:0]             total_c;
	logic [DVD_W-1:0]          kdvd_c;
	logic [TS_W-1:0]           dt_c;
	logic signed [DIFF_W-1:0]  adiff_c;
	logic [PROD_W-1:0]         rnd_c;
	logic signed [NV_W-1:0]    nv_c;
	logic                      out_free;

	wave_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	wave_div #(
		.DVD_W (DVD_W),
		.DVS_W (DVS_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.hi     (div_hi_q),
		.lo     (div_lo_q),
		.den    (div_den_q),
		.sts    (div_sts),
		.quot   (div_quot)
	);

	// start the divider from the three launch states; operands are staged
	assign div_req.start = (state_q == S_ADIV) || (state_q == S_VDIV) || (state_q == S_KDIV);
	assign div_req.count = div_cnt_q;

	// offset of the sample from the span center, doubled to keep half steps exact
	assign span_c  = SPAN_W'(cfg.axis_max) - SPAN_W'(cfg.axis_min);
	assign rel_c   = SPAN_W'(raw_q) - SPAN_W'(cfg.axis_min);
	assign twice_c = (ANGLE_W'(rel_c) <<< 1) - ANGLE_W'(span_c);

	// the one multiplier, fed from registered operands
	assign prod_c     = mul_a_q * mul_b_q;
	assign prod_mag_c = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);

	// rounding adds half the divisor before dividing magnitudes
	assign amag_c = (DVD_W'(prod_mag_c) << ANGLE_FRAC_BITS) + DVD_W'(span_q);
	assign vmag_c = (DVD_W'(prod_mag_c) << VELOCITY_FRAC_BITS)
		+ (DVD_W'(dt_q) << (ANGLE_FRAC_BITS - 1));
	assign total_c = (TS_W + 1)'(dt_q) + (TS_W + 1)'(cfg.tau_us);
	assign kdvd_c  = (DVD_W'(dt_q) << A_FRAC) + DVD_W'(total_c >> 1);

	assign dt_c    = ts_q - last_ts_q;
	assign adiff_c = DIFF_W'(angle_q) - DIFF_W'(prev_angle_q);

	// smoothing step: round (dv - v) * a / 2^16 away from zero
	assign rnd_c = (prod_mag_c + (PROD_W'(1) << (A_FRAC - 1))) >> A_FRAC;
	assign nv_c  = prod_q[PROD_W-1] ? NV_W'(vel_q) - NV_W'(rnd_c) : NV_W'(vel_q) + NV_W'(rnd_c);

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			prev_angle_q <= '0;
			vel_q        <= '0;
			last_ts_q    <= '0;
			have_prev_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// drop the result once taken, unless the next one replaces it
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						raw_q   <= raw_position;
						ts_q    <= timestamp_us;
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					span_q  <= span_c;
					mul_a_q <= MUL_A_W'(twice_c);
					mul_b_q <= MUL_B_W'(cfg.range_eff);
					if (span_c[SPAN_W-1] || span_c == '0) begin
						// empty or inverted span: angle is zero
						angle_q <= '0;
						state_q <= S_VSTART;
					end else begin
						state_q <= S_AMUL;
					end
				end
				S_AMUL: begin
					prod_q  <= prod_c;
					state_q <= S_APREP;
				end
				S_APREP: begin
					sign_q    <= prod_q[PROD_W-1];
					div_hi_q  <= amag_c >> QA_W;
					div_lo_q  <= QUOT_W'(amag_c[QA_W-1:0]) << (QUOT_W - QA_W);
					div_den_q <= DVS_W'(span_q) << 1;
					div_cnt_q <= CNT_W'(QA_W);
					state_q   <= S_ADIV;
				end
				S_ADIV: begin
					state_q <= S_AWAIT;
				end
				S_AWAIT: begin
					if (div_sts.done) begin
						// saturate to the angle range, then apply the sign
						if (!sign_q) begin
							angle_q <= (div_sts.ovf || div_quot > QUOT_W'(ANGLE_MAX))
								? ANGLE_MAX : ANGLE_W'(div_quot);
						end else begin
							angle_q <= (div_sts.ovf || div_quot > QUOT_W'(unsigned'(ANGLE_MIN)))
								? ANGLE_MIN : ANGLE_W'(-div_quot);
						end
						state_q <= S_VSTART;
					end
				end
				S_VSTART: begin
					dt_q    <= dt_c;
					mul_a_q <= MUL_A_W'(adiff_c);
					mul_b_q <= US_PER_S;
					// hold the velocity on the first sample or a repeated timestamp
					if (!have_prev_q || dt_c == '0) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_VMUL;
					end
				end
				S_VMUL: begin
					prod_q  <= prod_c;
					state_q <= S_VPREP;
				end
				S_VPREP: begin
					sign_q    <= prod_q[PROD_W-1];
					div_hi_q  <= vmag_c >> QV_W;
					div_lo_q  <= QUOT_W'(vmag_c[QV_W-1:0]) << (QUOT_W - QV_W);
					div_den_q <= DVS_W'(dt_q) << ANGLE_FRAC_BITS;
					div_cnt_q <= CNT_W'(QV_W);
					state_q   <= S_VDIV;
				end
				S_VDIV: begin
					state_q <= S_VWAIT;
				end
				S_VWAIT: begin
					if (div_sts.done) begin
						if (!sign_q) begin
							dv_q <= (div_sts.ovf || div_quot[QUOT_W-1]) ? VEL_MAX : VEL_W'(div_quot);
						end else begin
							dv_q <= (div_sts.ovf || div_quot > QUOT_W'(unsigned'(VEL_MIN)))
								? VEL_MIN : VEL_W'(-div_quot);
						end
						state_q <= S_KPREP;
					end
				end
				S_KPREP: begin
					// smoothing factor a = dt / (dt + tau) in Q16
					div_hi_q  <= kdvd_c >> QK_W;
					div_lo_q  <= QUOT_W'(kdvd_c[QK_W-1:0]) << (QUOT_W - QK_W);
					div_den_q <= DVS_W'(total_c);
					div_cnt_q <= CNT_W'(QK_W);
					state_q   <= S_KDIV;
				end
				S_KDIV: begin
					state_q <= S_KWAIT;
				end
				S_KWAIT: begin
					if (div_sts.done) begin
						mul_a_q <= MUL_A_W'(dv_q) - MUL_A_W'(vel_q);
						mul_b_q <= MUL_B_W'(div_quot[QK_W-1:0]);
						state_q <= S_SMUL;
					end
				end
				S_SMUL: begin
					prod_q  <= prod_c;
					state_q <= S_SUPD;
				end
				S_SUPD: begin
					if (nv_c > NV_W'(VEL_MAX)) begin
						vel_q <= VEL_MAX;
					end else if (nv_c < NV_W'(VEL_MIN)) begin
						vel_q <= VEL_MIN;
					end else begin
						vel_q <= VEL_W'(nv_c);
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					// advance only when the result register is free
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_angle_q  <= angle_q;
						out_vel_q    <= vel_q;
						out_vvalid_q <= have_prev_q;
						prev_angle_q <= angle_q;
						last_ts_q    <= ts_q;
						have_prev_q  <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready       = (state_q == S_IDLE);
	assign out_valid      = out_valid_q;
	assign angle_q8       = out_angle_q;
	assign velocity_q4    = out_vel_q;
	assign velocity_valid = out_vvalid_q;

	`WAVE_ASSERT_IMP(a_done_when_waiting, clk, arst_n, div_sts.done, state_q == S_AWAIT || state_q == S_VWAIT || state_q == S_KWAIT, "divider finished outside a wait state")
	`WAVE_ASSERT_IMP(a_dt_nonzero, clk, arst_n, state_q == S_VDIV, dt_q != '0, "velocity division with zero dt")
	`WAVE_ASSERT_IMP(a_first_vel_zero, clk, arst_n, out_valid_q && !out_vvalid_q, out_vel_q == '0, "velocity nonzero before a previous sample")

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import wave_pkg::*;

	// Cycles with no handshake on any channel before the run is declared hung.
	localparam int STALL_LIMIT = 2000;
	// Cycles to watch for stray results once the last expected one has come.
	localparam int TAIL_CYCLES = 100;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] angle;
		logic signed [VEL_W-1:0]   velocity;
		logic                      vel_valid;
	} estimate_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CFG_DATA_W-1:0]     cfg_data;
	logic                      in_valid;
	logic                      in_ready;
	logic signed [RAW_W-1:0]   raw_position;
	logic [TS_W-1:0]           timestamp_us;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [ANGLE_W-1:0] angle_q8;
	logic signed [VEL_W-1:0]   velocity_q4;
	logic                      velocity_valid;

	// Percent of cycles in which the sender holds back or the receiver stalls.
	int unsigned in_idle_pct;
	int unsigned out_idle_pct;
	int          failures = 0;
	int          quiet_cycles = 0;

	// Mirror of the register file.
	longint axis_lo;
	longint axis_hi;
	longint range_cfg;
	longint tau_us;

	// Mirror of the tracking state.
	longint      prev_angle;
	longint      smoothed_vel;
	logic [31:0] last_ts;
	bit          have_prev;

	estimate_t expected_estimates[$];

	wheel_angle_velocity_estimator dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.raw_position   (raw_position),
		.timestamp_us   (timestamp_us),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.angle_q8       (angle_q8),
		.velocity_q4    (velocity_q4),
		.velocity_valid (velocity_valid)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Round num/den to nearest, ties away from zero; den is positive.
	function automatic longint round_div(input longint num, input longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q   = (mag + den / 2) / den;
		return (num < 0) ? -q : q;
	endfunction

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Map a raw sample onto +-range/2 degrees in Q(ANGLE_FRAC_BITS).
	function automatic longint angle_of(input longint raw);
		longint rng;
		longint span;
		longint num;
		rng  = (range_cfg != 0) ? range_cfg : longint'(RANGE_DEF);
		span = axis_hi - axis_lo;
		if (span <= 0)
			return 0;
		num = (2 * (raw - axis_lo) - span) * rng * (longint'(1) << ANGLE_FRAC_BITS_DEF);
		return clamp(round_div(num, 2 * span), longint'(ANGLE_MIN), longint'(ANGLE_MAX));
	endfunction

	// Advance the tracking state by one sample and return the estimate it reports.
	function automatic estimate_t predict_estimate(input logic signed [RAW_W-1:0] raw,
			input logic [TS_W-1:0] ts);
		estimate_t   est;
		logic [31:0] dt32;
		longint      ang;
		longint      dt;
		longint      dv;
		longint      total;
		longint      gain;
		longint      nv;
		ang           = angle_of(longint'(raw));
		dt32          = ts - last_ts;
		dt            = longint'(dt32);
		est.vel_valid = have_prev;
		// Skip the velocity on the first sample and on a repeated timestamp.
		if (have_prev && dt != 0) begin
			dv = round_div((ang - prev_angle) * longint'(US_PER_S)
					* (longint'(1) << VELOCITY_FRAC_BITS_DEF), dt << ANGLE_FRAC_BITS_DEF);
			dv    = clamp(dv, longint'(VEL_MIN), longint'(VEL_MAX));
			total = dt + tau_us;
			gain  = ((dt << A_FRAC) + total / 2) / total;
			nv    = smoothed_vel + round_div((dv - smoothed_vel) * gain, longint'(1) << A_FRAC);
			smoothed_vel = clamp(nv, longint'(VEL_MIN), longint'(VEL_MAX));
		end
		prev_angle   = ang;
		last_ts      = ts;
		have_prev    = 1'b1;
		est.angle    = ang[ANGLE_W-1:0];
		est.velocity = smoothed_vel[VEL_W-1:0];
		return est;
	endfunction

	task automatic reset_model();
		axis_lo      = longint'(AXIS_MIN_RST);
		axis_hi      = longint'(AXIS_MAX_RST);
		range_cfg    = longint'(RANGE_DEF);
		tau_us       = longint'(TAU_RST);
		prev_angle   = 0;
		smoothed_vel = 0;
		last_ts      = '0;
		have_prev    = 1'b0;
	endtask

	// Offer one item, hold it until accepted, then queue its prediction.
	// Valid stays high on return: the caller sends again or drains in the same step.
	task automatic send_sample(input logic signed [RAW_W-1:0] raw, input logic [TS_W-1:0] ts);
		while ($urandom_range(0, 99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		raw_position <= raw;
		timestamp_us <= ts;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		expected_estimates.push_back(predict_estimate(raw, ts));
	endtask

	// Drop valid and wait until every queued estimate has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_estimates.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_AXIS_MIN:  axis_lo   = longint'($signed(data[RAW_W-1:0]));
			REG_AXIS_MAX:  axis_hi   = longint'($signed(data[RAW_W-1:0]));
			REG_RANGE_DEG: range_cfg = longint'(data[RANGE_W-1:0]);
			REG_TAU_US:    tau_us    = longint'(data[TAU_W-1:0]);
			default: ;
		endcase
	endtask

	// Write all four registers once the block has gone idle.
	task automatic configure(input int amin, input int amax, input int rng, input int tau);
		drain_results();
		write_reg(REG_AXIS_MIN, CFG_DATA_W'(amin[RAW_W-1:0]));
		write_reg(REG_AXIS_MAX, CFG_DATA_W'(amax[RAW_W-1:0]));
		write_reg(REG_RANGE_DEG, CFG_DATA_W'(rng[RANGE_W-1:0]));
		write_reg(REG_TAU_US, tau[TAU_W-1:0]);
	endtask

	task automatic configure_random();
		int a;
		int b;
		int t;
		int kind;
		int rng;
		int tau;
		kind = $urandom_range(0, 9);
		a    = int'($urandom_range(0, 131071)) - 65536;
		b    = int'($urandom_range(0, 131071)) - 65536;
		if (kind == 0) begin
			// degenerate span
			b = a;
		end else if (kind >= 2 && a > b) begin
			t = a;
			a = b;
			b = t;
		end
		rng = ($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(1, 4095));
		tau = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 1048575))
				: int'($urandom_range(1, 50000));
		configure(a, b, rng, tau);
	endtask

	// Default registers: first sample, raw extremes, repeated and wrapping timestamps.
	task automatic test_reset_defaults();
		send_sample(17'sd0, 32'd1000);
		send_sample(17'sd65535, 32'd2000);
		send_sample(-17'sd65536, 32'd3000);
		send_sample(17'sd32767, 32'd3000);
		send_sample(17'sd32768 - 17'sd1, 32'hFFFF_FF00);
		send_sample(-17'sd1, 32'h0000_0100);
	endtask

	// Register corners: tiny span with saturation, zero and inverted spans,
	// zero range, tau extremes, full-width axis.
	task automatic test_config_corners();
		configure(0, 1, 4095, 0);
		send_sample(17'sd65535, 32'd5000);
		send_sample(-17'sd65536, 32'd5001);
		send_sample(17'sd1, 32'd5002);
		configure(5, 5, 0, 1048575);
		send_sample(17'sd5, 32'd9000);
		send_sample(17'sd100, 32'd9500);
		configure(65535, -65536, 1, 1);
		send_sample(17'sd0, 32'd9600);
		send_sample(-17'sd65536, 32'd9700);
		configure(-65536, 65535, 3600, 20000);
		send_sample(-17'sd65536, 32'hFFFF_FFFF);
		send_sample(17'sd65535, 32'h0000_0000);
		send_sample(17'sd0, 32'h0000_0001);
	endtask

	// Mostly steady tracking with small time steps and a wandering wheel,
	// mixed with repeated timestamps, jumps and an occasional full drain.
	task automatic test_random_tracking(input int n_items);
		logic [TS_W-1:0] ts;
		int              walk;
		int              pick;
		int              sent;
		logic signed [RAW_W-1:0] raw;
		ts   = ($urandom_range(0, 2) == 0) ? (32'hFFFF_FFFF - $urandom_range(0, 200000))
				: $urandom();
		walk = int'((axis_lo + axis_hi) / 2);
		for (sent = 0; sent < n_items; sent++) begin
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				ts   = ts + $urandom_range(1, 5000);
				walk = walk + int'($urandom_range(0, 4000)) - 2000;
				if ($urandom_range(0, 19) == 0)
					walk = int'($urandom_range(0, 131071)) - 65536;
				walk = int'(clamp(longint'(walk), -65536, 65535));
				raw  = walk[RAW_W-1:0];
			end else if (pick < 88) begin
				// hold the timestamp, move the wheel
				raw = RAW_W'($urandom());
			end else begin
				ts  = $urandom();
				raw = RAW_W'($urandom());
			end
			send_sample(raw, ts);
			// Pause now and then until every result is back.
			if ($urandom_range(0, 49) == 0)
				drain_results();
		end
	endtask

	// Drive the receiver's stalls.
	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= out_idle_pct);

	// Compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		estimate_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (expected_estimates.size() == 0) begin
				$display("%0t: unexpected result: angle %0d velocity %0d valid %0b",
						$time, angle_q8, velocity_q4, velocity_valid);
				failures++;
			end else begin
				want = expected_estimates.pop_front();
				if (angle_q8 !== want.angle) begin
					$display("%0t: angle_q8 expected %0d actual %0d",
							$time, $signed(want.angle), angle_q8);
					failures++;
				end
				if (velocity_q4 !== want.velocity) begin
					$display("%0t: velocity_q4 expected %0d actual %0d",
							$time, $signed(want.velocity), velocity_q4);
					failures++;
				end
				if (velocity_valid !== want.vel_valid) begin
					$display("%0t: velocity_valid expected %0b actual %0b",
							$time, want.vel_valid, velocity_valid);
					failures++;
				end
			end
		end
	end

	// Watchdog: end the run when no channel has moved for too long.
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || cfg_we || (in_valid && in_ready === 1'b1)
				|| (out_valid === 1'b1 && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int phase;
		int k;
		in_idle_pct  = 34;
		out_idle_pct = 76;
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_index    <= REG_AXIS_MIN;
		cfg_data     <= '0;
		in_valid     <= 1'b0;
		raw_position <= '0;
		timestamp_us <= '0;
		reset_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_config_corners();

		// Sender light and receiver heavy, then swapped, then no idling at all.
		for (phase = 0; phase < 3; phase++) begin
			drain_results();
			in_idle_pct  = (phase == 0) ? 34 : ((phase == 1) ? 76 : 0);
			out_idle_pct = (phase == 0) ? 76 : ((phase == 1) ? 34 : 0);
			for (k = 0; k < 4; k++) begin
				configure_random();
				test_random_tracking(66);
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
